>>> src/i2cmws_pkg.sv
`timescale 1ns / 1ps

package i2cmws_pkg;

  // Stream payload widths
  localparam int IN_TUSER_W  = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_TDATA_W = 16;

  // Data buffer depth, one entry per byte position
  localparam int BUF_DEPTH = 256;

  // Input item kinds
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_BEGIN  = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  // Bus commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_SEND  = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  // Transfer results
  localparam logic [2:0] RES_SENT      = 3'd0;
  localparam logic [2:0] RES_START_ERR = 3'd1;
  localparam logic [2:0] RES_ADDR_ERR  = 3'd2;
  localparam logic [2:0] RES_DATA_ERR  = 3'd3;
  localparam logic [2:0] RES_EXHAUSTED = 3'd4;

  // Master transmitter status codes (prescaler bits masked)
  localparam logic       WR_BIT       = 1'b0;
  localparam logic [7:0] SC_START     = 8'h08;
  localparam logic [7:0] SC_REP_START = 8'h10;
  localparam logic [7:0] SC_SLA_ACK   = 8'h18;
  localparam logic [7:0] SC_SLA_NACK  = 8'h20;
  localparam logic [7:0] SC_DATA_ACK  = 8'h28;
  localparam logic [7:0] SC_DATA_NACK = 8'h30;
  localparam logic [7:0] SC_ARB_LOST  = 8'h38;

  localparam logic [7:0] RETRY_LIMIT_RST = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_ADDR  = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] slave_address;
    logic [7:0] byte_count;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic [7:0] status_code;
  } item_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [2:0] result_code;
  } result_t;

  // Upcoming sequencer state, used to prefetch the next buffer byte
  typedef struct packed {
    phase_t     phase_nxt;
    logic [7:0] pos_nxt;
  } look_t;

endpackage

>>> src/i2c_master_write_sequencer_unit.sv
// A result transfer is registered in the input stage and then in the result register.
// Throughput: one item per cycle unless the output stalls; the buffer byte an item may
// send is prefetched from the single-read-port RAM in the cycle the item is taken in.
// Reset (rst_n low, synchronous): phase idle, counters and target cleared, retry limit = 10,
// both stages empty. The data buffer is not cleared.
`timescale 1ns / 1ps

module i2c_master_write_sequencer_unit
  import i2cmws_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // config write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data,     // retry limit
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // slave_address, byte_count, byte_index,
                                               // data_byte, status_code, 1 bit pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,     // mode
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,    // tx_byte, result_code, 5 bits pad
  output logic [OUT_TUSER_W-1:0] out_tuser     // command, done_res
);

  logic [7:0] retry_limit_r;

  logic       s1_v_r;
  item_t      s1_item_r;
  item_t      in_item;
  logic       accept;
  logic       fire;

  logic       out_v_r;
  result_t    out_res_r;
  result_t    res;
  look_t      look;

  logic       wr_en;
  logic [7:0] wr_addr;
  logic [7:0] rd_addr;
  logic [7:0] ram_q;
  logic       byp_r;
  logic [7:0] byp_data_r;
  logic [7:0] rd_byte;

  // Config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RST;
    end else if (cfg_valid) begin
      retry_limit_r <= cfg_data;
    end
  end

  // Unpack input transfer
  assign in_item = '{mode:          in_tuser[1:0],
                     slave_address: in_tdata[6:0],
                     byte_count:    in_tdata[14:7],
                     byte_index:    in_tdata[22:15],
                     data_byte:     in_tdata[30:23],
                     status_code:   in_tdata[38:31]};

  // Stage handshakes
  assign fire      = s1_v_r & (~out_v_r | out_tready);
  assign in_tready = ~s1_v_r | fire;
  assign accept    = in_tvalid & in_tready;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  // Buffer: loads write on processing, next byte prefetched on accept
  assign wr_en   = fire & (s1_item_r.mode == MODE_LOAD);
  assign wr_addr = s1_item_r.byte_index;
  assign rd_addr = (look.phase_nxt == PH_DATA) ? look.pos_nxt + 8'd1 : 8'd0;

  i2cmws_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s1_item_r.data_byte),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Forward a load that lands on the prefetched position in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (accept) begin
      byp_r <= wr_en & (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data_r <= s1_item_r.data_byte;
    end
  end

  assign rd_byte = byp_r ? byp_data_r : ram_q;

  i2cmws_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (s1_item_r),
    .rd_byte     (rd_byte),
    .retry_limit (retry_limit_r),
    .look        (look),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_res_r.result_code, out_res_r.tx_byte};
  assign out_tuser  = {out_res_r.done_res, out_res_r.command};

endmodule

>>> src/i2cmws_ram.sv
`timescale 1ns / 1ps

module i2cmws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/i2cmws_fsm.sv
`timescale 1ns / 1ps

module i2cmws_fsm
  import i2cmws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  item_t      item,
  input  logic [7:0] rd_byte,
  input  logic [7:0] retry_limit,
  output look_t      look,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] attempt_r, attempt_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [6:0] tgt_r, tgt_nxt;
  logic [7:0] len_r, len_nxt;

  logic [7:0] nack_cnt;
  logic       retry_ok;
  logic       nack_ok;
  logic [7:0] pos_inc;
  logic       last_byte;
  logic       begin_ok;

  // Shared decision terms
  assign nack_cnt  = (attempt_r == 8'hFF) ? attempt_r : attempt_r + 8'd1;
  assign retry_ok  = attempt_r < retry_limit;
  assign nack_ok   = nack_cnt < retry_limit;
  assign pos_inc   = pos_r + 8'd1;
  assign last_byte = pos_inc >= len_r;
  assign begin_ok  = retry_limit != 8'd0;

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    attempt_nxt = attempt_r;
    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    len_nxt     = len_r;
    if (fire) begin
      case (item.mode)
        MODE_BEGIN: begin
          tgt_nxt     = item.slave_address;
          len_nxt     = item.byte_count;
          attempt_nxt = 8'd0;
          pos_nxt     = 8'd0;
          phase_nxt   = begin_ok ? PH_START : PH_IDLE;
        end
        MODE_STATUS: begin
          case (phase_r)
            PH_START: begin
              if (item.status_code inside {SC_START, SC_REP_START}) begin
                phase_nxt = PH_ADDR;
              end else if (item.status_code != SC_ARB_LOST) begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_ADDR: begin
              if (item.status_code == SC_SLA_ACK) begin
                pos_nxt   = 8'd0;
                phase_nxt = (len_r == 8'd0) ? PH_IDLE : PH_DATA;
              end else if (item.status_code == SC_SLA_NACK) begin
                attempt_nxt = nack_cnt;
                phase_nxt   = nack_ok ? PH_START : PH_IDLE;
              end else if (item.status_code == SC_ARB_LOST) begin
                phase_nxt = retry_ok ? PH_START : PH_IDLE;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_DATA: begin
              if (item.status_code == SC_DATA_ACK) begin
                pos_nxt   = pos_inc;
                phase_nxt = last_byte ? PH_IDLE : PH_DATA;
              end else if (item.status_code == SC_DATA_NACK) begin
                attempt_nxt = nack_cnt;
                phase_nxt   = nack_ok ? PH_START : PH_IDLE;
              end else if (item.status_code == SC_ARB_LOST) begin
                phase_nxt = retry_ok ? PH_START : PH_IDLE;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Result for the item in the input stage
  always_comb begin
    res = '{command: CMD_NONE, tx_byte: 8'd0, done_res: 1'b0, result_code: RES_SENT};
    case (item.mode)
      MODE_BEGIN: begin
        if (begin_ok) begin
          res.command = CMD_START;
        end else begin
          res.done_res    = 1'b1;
          res.result_code = RES_EXHAUSTED;
        end
      end
      MODE_STATUS: begin
        case (phase_r)
          PH_START: begin
            if (item.status_code inside {SC_START, SC_REP_START}) begin
              res.command = CMD_SEND;
              res.tx_byte = {tgt_r, WR_BIT};
            end else if (item.status_code == SC_ARB_LOST) begin
              res.command = CMD_START;
            end else begin
              res.done_res    = 1'b1;
              res.result_code = RES_START_ERR;
            end
          end
          PH_ADDR: begin
            if (item.status_code == SC_SLA_ACK) begin
              if (len_r == 8'd0) begin
                res.command  = CMD_STOP;
                res.done_res = 1'b1;
              end else begin
                res.command = CMD_SEND;
                res.tx_byte = rd_byte;
              end
            end else if (item.status_code == SC_SLA_NACK) begin
              if (nack_ok) begin
                res.command = CMD_START;
              end else begin
                res.done_res    = 1'b1;
                res.result_code = RES_EXHAUSTED;
              end
            end else if (item.status_code == SC_ARB_LOST) begin
              if (retry_ok) begin
                res.command = CMD_START;
              end else begin
                res.done_res    = 1'b1;
                res.result_code = RES_EXHAUSTED;
              end
            end else begin
              res.command     = CMD_STOP;
              res.done_res    = 1'b1;
              res.result_code = RES_ADDR_ERR;
            end
          end
          PH_DATA: begin
            if (item.status_code == SC_DATA_ACK) begin
              if (last_byte) begin
                res.command  = CMD_STOP;
                res.done_res = 1'b1;
              end else begin
                res.command = CMD_SEND;
                res.tx_byte = rd_byte;
              end
            end else if (item.status_code == SC_DATA_NACK) begin
              if (nack_ok) begin
                res.command = CMD_START;
              end else begin
                res.done_res    = 1'b1;
                res.result_code = RES_EXHAUSTED;
              end
            end else if (item.status_code == SC_ARB_LOST) begin
              if (retry_ok) begin
                res.command = CMD_START;
              end else begin
                res.done_res    = 1'b1;
                res.result_code = RES_EXHAUSTED;
              end
            end else begin
              res.command     = CMD_STOP;
              res.done_res    = 1'b1;
              res.result_code = RES_DATA_ERR;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign look = '{phase_nxt: phase_nxt, pos_nxt: pos_nxt};

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      attempt_r <= 8'd0;
      pos_r     <= 8'd0;
      tgt_r     <= 7'd0;
      len_r     <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      attempt_r <= attempt_nxt;
      pos_r     <= pos_nxt;
      tgt_r     <= tgt_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

>>> src/i2cmws_checker.sv
`timescale 1ns / 1ps

module i2cmws_checker
  import i2cmws_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Result code only carries meaning on a finished transfer
  a_code_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[10:8] == RES_SENT)
    else $error("result code set without done");

  // Transmit byte is zero unless a byte is sent
  a_tx_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != CMD_SEND |-> out_tdata[7:0] == 8'd0)
    else $error("tx byte without send command");

  // A finished transfer never asks for another byte
  a_done_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] != CMD_SEND)
    else $error("send command on finished transfer");

endmodule

bind i2c_master_write_sequencer_unit i2cmws_checker u_i2cmws_checker (.*);
